// File: rtl/i2p_pkg.sv
`timescale 1ns / 1ps

package i2p_pkg;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_CLOSE    = 2'd2,
    ERR_OPEN     = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROC,
    S_FLUSH,
    S_FIN
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  // high priority: anything but '+' and '-'
  function automatic logic is_high_prio(input logic [7:0] c);
    return !((c == CH_PLUS) || (c == CH_MINUS));
  endfunction

endpackage

// File: rtl/i2p_cell.sv
`timescale 1ns / 1ps

module i2p_cell
  import i2p_pkg::*;
(
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  logic [7:0] up_i,
  input  logic [7:0] down_i,
  output logic [7:0] data_o
);

  logic [7:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.push) begin
      data_d = up_i;
    end else if (ctl_i.pop) begin
      data_d = down_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: rtl/infix_to_postfix_converter.sv
`timescale 1ns / 1ps
// Each result waits in a pending register until the next one of its run is found or the run
// ends in S_FIN; then it moves to the output register. A new character is taken only in S_IDLE;
// S_PROC emits a digit, pops and emits stack entries or pushes an operator, and S_FIN ends it;
// for the last one of an expression S_FLUSH first empties the stack. Output stalls can hold these up.
// The operator stack is a shift chain of STACK_DEPTH cells; top of stack is cell 0.
// Reset (rst_ni low, async): control, count and error clear; cell contents do not.

module infix_to_postfix_converter
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  logic        s_axis_tlast,   // end_of_expr
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_symbol, [8] expr_done, [10:9] error_code
  output logic        m_axis_tuser,   // has_symbol
  output logic        m_axis_tlast    // last_of_run
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_e      state_q, state_d;
  logic [7:0]  sym_q, sym_d;
  logic        last_q, last_d;
  logic [CW-1:0] cnt_q, cnt_d;
  err_e        err_q, err_d;
  logic        pend_valid_q, pend_valid_d;
  logic [7:0]  pend_sym_q, pend_sym_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_sym_q, out_sym_d;
  logic        out_has_q, out_has_d;
  logic        out_last_q, out_last_d;
  logic        out_done_q, out_done_d;
  err_e        out_err_q, out_err_d;

  cell_ctl_t   cell_ctl;
  logic [7:0]  cell_data [STACK_DEPTH];
  logic [7:0]  top;
  logic        slot_free, can_emit, emit, stack_full, sym_digit;
  logic [7:0]  emit_sym;
  state_e      after_item;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [7:0] up, down;
    if (i == 0) begin : g_first
      assign up = sym_q;
    end else begin : g_mid
      assign up = cell_data[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign down = cell_data[i];
    end else begin : g_inner
      assign down = cell_data[i+1];
    end
    i2p_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl),
      .up_i   (up),
      .down_i (down),
      .data_o (cell_data[i])
    );
  end

  assign top        = cell_data[0];
  assign slot_free  = !out_valid_q || m_axis_tready;
  assign can_emit   = !pend_valid_q || slot_free;
  assign stack_full = (cnt_q == CW'(STACK_DEPTH));
  assign sym_digit  = sym_q inside {[CH_ZERO:CH_NINE]};
  assign after_item = last_q ? S_FLUSH : S_FIN;

  always_comb begin
    state_d      = state_q;
    sym_d        = sym_q;
    last_d       = last_q;
    cnt_d        = cnt_q;
    err_d        = err_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_sym_d    = out_sym_q;
    out_has_d    = out_has_q;
    out_last_d   = out_last_q;
    out_done_d   = out_done_q;
    out_err_d    = out_err_q;
    cell_ctl     = '0;
    emit         = 1'b0;
    emit_sym     = top;
    s_axis_tready = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          sym_d   = s_axis_tdata;
          last_d  = s_axis_tlast;
          state_d = S_PROC;
        end
      end
      S_PROC: begin
        if (sym_digit) begin
          if (can_emit) begin
            emit     = 1'b1;
            emit_sym = sym_q;
            state_d  = after_item;
          end
        end else if (sym_q == CH_CLOSE) begin
          if (cnt_q == '0) begin
            if (err_q == ERR_NONE) err_d = ERR_CLOSE;
            state_d = after_item;
          end else if (top == CH_OPEN) begin
            cell_ctl.pop = 1'b1;
            cnt_d        = cnt_q - CW'(1);
            state_d      = after_item;
          end else if (can_emit) begin
            cell_ctl.pop = 1'b1;
            cnt_d        = cnt_q - CW'(1);
            emit         = 1'b1;
          end
        end else if ((sym_q != CH_OPEN) && (cnt_q != '0) && (top != CH_OPEN) &&
                     !(is_high_prio(sym_q) && !is_high_prio(top))) begin
          if (can_emit) begin
            cell_ctl.pop = 1'b1;
            cnt_d        = cnt_q - CW'(1);
            emit         = 1'b1;
          end
        end else begin
          if (stack_full) begin
            if (err_q == ERR_NONE) err_d = ERR_OVERFLOW;
          end else begin
            cell_ctl.push = 1'b1;
            cnt_d         = cnt_q + CW'(1);
          end
          state_d = after_item;
        end
      end
      S_FLUSH: begin
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else if (top == CH_OPEN) begin
          cell_ctl.pop = 1'b1;
          cnt_d        = cnt_q - CW'(1);
          if (err_q == ERR_NONE) err_d = ERR_OPEN;
        end else if (can_emit) begin
          cell_ctl.pop = 1'b1;
          cnt_d        = cnt_q - CW'(1);
          emit         = 1'b1;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          if (pend_valid_q || last_q) begin
            out_valid_d  = 1'b1;
            out_sym_d    = pend_valid_q ? pend_sym_q : 8'd0;
            out_has_d    = pend_valid_q;
            out_last_d   = 1'b1;
            out_done_d   = last_q;
            out_err_d    = last_q ? err_q : ERR_NONE;
            pend_valid_d = 1'b0;
          end
          if (last_q) begin
            err_d = ERR_NONE;
            cnt_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // hold each result until the next one is emitted so the last one of a run can be marked
    if (emit) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_sym_d   = pend_sym_q;
        out_has_d   = 1'b1;
        out_last_d  = 1'b0;
        out_done_d  = 1'b0;
        out_err_d   = ERR_NONE;
      end
      pend_valid_d = 1'b1;
      pend_sym_d   = emit_sym;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      err_q        <= ERR_NONE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      err_q        <= err_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q      <= sym_d;
    last_q     <= last_d;
    pend_sym_q <= pend_sym_d;
    out_sym_q  <= out_sym_d;
    out_has_q  <= out_has_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
    out_err_q  <= out_err_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_err_q, out_done_q, out_sym_q};
  assign m_axis_tuser  = out_has_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: rtl/i2p_checker.sv
`timescale 1ns / 1ps

module i2p_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transfer changed while stalled");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tlast)
    else $error("expr_done without tlast");

  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[10:9] != 2'd0) |-> m_axis_tdata[8])
    else $error("error code outside final transfer");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[8] && (m_axis_tdata[7:0] == 8'd0))
    else $error("bad empty end marker");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
